// ===== hdl/ttl_cache_slot_policy_assert.svh =====
// Assertion macros used by the RTL file tcsp_back.
// Each expects signals named clk and rst_n in the using scope.
`ifndef TTL_CACHE_SLOT_POLICY_ASSERT_SVH
`define TTL_CACHE_SLOT_POLICY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TCSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tcsp_pkg.sv =====
package tcsp_pkg;

    // table geometry
    localparam int ENTRIES = 5;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int TTL_W   = 32;
    localparam int BUF_W   = 3;
    localparam int CAUSE_W = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_EXPIRED = 2'd1,
        CAUSE_OLDEST  = 2'd2
    } cause_t;

    // classified command: arg is the TTL on insert, the elapsed time on tick
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [TTL_W-1:0] arg;
    } cmd_t;

endpackage

// ===== hdl/tcsp_req_if.sv =====
interface tcsp_req_if
    import tcsp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   name_key;
    logic [TTL_W-1:0]   entry_ttl;
    logic [TTL_W-1:0]   elapsed_seconds;

    modport source (output valid, operation, name_key, entry_ttl, elapsed_seconds,
                    input ready);
    modport sink   (input valid, operation, name_key, entry_ttl, elapsed_seconds,
                    output ready);
endinterface

// ===== hdl/tcsp_rsp_if.sv =====
interface tcsp_rsp_if
    import tcsp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [BUF_W-1:0]   buffer_id;
    logic [CAUSE_W-1:0] evict_cause;
    logic [KEY_W-1:0]   evicted_key;

    modport source (output valid, hit, buffer_id, evict_cause, evicted_key,
                    input ready);
    modport sink   (input valid, hit, buffer_id, evict_cause, evicted_key,
                    output ready);
endinterface

// ===== hdl/tcsp_front.sv =====
module tcsp_front
    import tcsp_pkg::*;
(
    tcsp_req_if.sink   req,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    // decode the incoming word into a command; code three becomes a no-op
    always_comb
    begin
        cmd.op  = op_t'(req.operation);
        cmd.key = req.name_key;
        unique case (cmd.op)
            OP_TICK:   cmd.arg = req.elapsed_seconds;
            OP_INSERT: cmd.arg = req.entry_ttl;
            default:   cmd.arg = '0;
        endcase
    end

    // accept whenever the queue has room
    assign cmd_valid = req.valid;
    assign req.ready = cmd_ready;

endmodule

// ===== hdl/tcsp_queue.sv =====
module tcsp_queue
    import tcsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/tcsp_back.sv =====
module tcsp_back
    import tcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    tcsp_rsp_if.source rsp
);

`include "ttl_cache_slot_policy_assert.svh"

    // table: position 0 oldest
    logic [KEY_W-1:0] key_reg  [ENTRIES];
    logic [KEY_W-1:0] key_next [ENTRIES];
    logic [TTL_W-1:0] ttl_reg  [ENTRIES];
    logic [TTL_W-1:0] ttl_next [ENTRIES];
    logic [IDX_W-1:0] buf_reg  [ENTRIES];
    logic [IDX_W-1:0] buf_next [ENTRIES];
    logic [CNT_W-1:0] count_reg, count_next;

    // output word register
    logic               rsp_valid_reg;
    logic               hit_reg, hit_next;
    logic [BUF_W-1:0]   buffer_id_reg, buffer_id_next;
    cause_t             cause_reg, cause_next;
    logic [KEY_W-1:0]   evicted_key_reg, evicted_key_next;

    logic [ENTRIES-1:0] live, match, expired;
    logic               hit_found, free_found, full, fire;
    logic [IDX_W-1:0]   hit_idx, free_idx, tail_idx;
    logic [ENTRIES-1:0] seen;

    assign cmd_ready = !rsp_valid_reg || rsp.ready;
    assign fire      = cmd_valid && cmd_ready;
    assign full      = (count_reg == CNT_W'(ENTRIES));
    assign tail_idx  = count_reg[IDX_W-1:0];

    // per-entry compares
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            live[i]    = (CNT_W'(i) < count_reg);
            match[i]   = live[i] && (ttl_reg[i] != '0) && (key_reg[i] == cmd.key);
            expired[i] = live[i] && (ttl_reg[i] == '0);
        end
    end

    // newest match wins for lookup, oldest expired slot for insert
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (expired[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // execute one command
    always_comb
    begin
        key_next         = key_reg;
        ttl_next         = ttl_reg;
        buf_next         = buf_reg;
        count_next       = count_reg;
        hit_next         = 1'b0;
        buffer_id_next   = '0;
        cause_next       = CAUSE_NONE;
        evicted_key_next = '0;
        unique case (cmd.op)
            OP_LOOKUP:
            begin
                if (hit_found)
                begin
                    hit_next       = 1'b1;
                    buffer_id_next = BUF_W'(buf_reg[hit_idx]);
                end
            end
            OP_INSERT:
            begin
                if (free_found)
                begin
                    key_next[free_idx] = cmd.key;
                    ttl_next[free_idx] = cmd.arg;
                    buffer_id_next     = BUF_W'(buf_reg[free_idx]);
                    cause_next         = CAUSE_EXPIRED;
                    evicted_key_next   = key_reg[free_idx];
                end
                else if (full)
                begin
                    for (int i = 0; i < ENTRIES - 1; i++)
                    begin
                        key_next[i] = key_reg[i + 1];
                        ttl_next[i] = ttl_reg[i + 1];
                        buf_next[i] = buf_reg[i + 1];
                    end
                    key_next[ENTRIES - 1] = cmd.key;
                    ttl_next[ENTRIES - 1] = cmd.arg;
                    buf_next[ENTRIES - 1] = buf_reg[0];
                    buffer_id_next        = BUF_W'(buf_reg[0]);
                    cause_next            = CAUSE_OLDEST;
                    evicted_key_next      = key_reg[0];
                end
                else
                begin
                    key_next[tail_idx] = cmd.key;
                    ttl_next[tail_idx] = cmd.arg;
                    buffer_id_next     = BUF_W'(buf_reg[tail_idx]);
                    count_next         = count_reg + 1'b1;
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (live[i])
                    begin
                        ttl_next[i] = (ttl_reg[i] > cmd.arg) ? ttl_reg[i] - cmd.arg : '0;
                    end
                end
            end
            OP_NOP:
            begin
            end
        endcase
    end

    // control state and buffer map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                buf_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
                buf_reg   <= buf_next;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload: keys, TTLs and the result word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            key_reg         <= key_next;
            ttl_reg         <= ttl_next;
            hit_reg         <= hit_next;
            buffer_id_reg   <= buffer_id_next;
            cause_reg       <= cause_next;
            evicted_key_reg <= evicted_key_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.buffer_id   = buffer_id_reg;
    assign rsp.evict_cause = cause_reg;
    assign rsp.evicted_key = evicted_key_reg;

    // buffer ids present in the map
    always_comb
    begin
        seen = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            seen = seen | (ENTRIES'(1) << buf_reg[i]);
        end
    end

    `TCSP_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(ENTRIES), "entry count overflow")
    `TCSP_ASSERT_IMP(a_buf_perm, 1'b1, &seen, "buffer map is not a permutation")
    `TCSP_ASSERT_NXT(a_evict_oldest, fire && cmd.op == OP_INSERT && full && !free_found,
        rsp.valid && rsp.evict_cause == CAUSE_OLDEST && count_reg == CNT_W'(ENTRIES),
        "full insert did not evict the oldest entry")
    `TCSP_ASSERT_IMP(a_hit_clean, rsp.valid && rsp.hit,
        rsp.evict_cause == CAUSE_NONE && rsp.evicted_key == '0,
        "lookup hit carries eviction data")

endmodule

// ===== hdl/ttl_cache_slot_policy.sv =====
// TTL cache slot table: lookup, insert and tick words arrive on req and each
// gives exactly one word on rsp. A word passes through a classifier, a
// two-word command queue and the table engine, which executes any command
// combinationally and registers the result; an accepted word is held in
// the queue and then in the output register before its result is valid.
// The sustained rate is one word per cycle while rsp is ready. Stalls on
// rsp back up into the queue and then into req.ready. Keys and TTLs of
// unused slots are never read; after reset the table is empty and buffer
// ids map one to one onto slots.
module ttl_cache_slot_policy
    import tcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tcsp_req_if.sink   req,
    tcsp_rsp_if.source rsp
);

    logic cmd_valid, cmd_ready;
    logic exec_valid, exec_ready;
    cmd_t cmd, exec_cmd;

    tcsp_front u_front (
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tcsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_cmd   (cmd),
        .pop_valid  (exec_valid),
        .pop_ready  (exec_ready),
        .pop_cmd    (exec_cmd)
    );

    tcsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (exec_valid),
        .cmd_ready (exec_ready),
        .cmd       (exec_cmd),
        .rsp       (rsp)
    );

endmodule
